// ----- rtl/core/spp_pkg.sv -----
// ----------------------------------------------------------------------------
// SPI range poller package
// Command and reply codes, register indexes and field widths shared by the
// poller core and its port checker.
// ----------------------------------------------------------------------------
package spp_pkg;

	localparam int unsigned WordW  = 16;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned DelayW = 12;
	localparam int unsigned TickW  = 8;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = DelayW;

	// Commands sent to the range board
	localparam logic [WordW-1:0] CMD_NONE  = 16'h0000;
	localparam logic [WordW-1:0] CMD_FIRE  = 16'hCC01;
	localparam logic [WordW-1:0] CMD_READ  = 16'hCC02;
	localparam logic [WordW-1:0] CMD_ALIVE = 16'hCC03;

	// Expected replies
	localparam logic [WordW-1:0] ACK_A     = 16'hBABE;
	localparam logic [WordW-1:0] ACK_B     = 16'hCABB;
	localparam logic [WordW-1:0] DATA_MASK = 16'hFF00;
	localparam logic [WordW-1:0] DATA_TAG  = 16'hDD00;

	// Request kinds
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_XFER = 1'b1;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_START_DELAY = 2'd0,
		CFG_FIRE_TICK   = 2'd1,
		CFG_READ_TICK   = 2'd2
	} cfg_idx_t;

	localparam logic [DelayW-1:0] START_DELAY_RST = 12'd2000;
	localparam logic [TickW-1:0]  FIRE_TICK_RST   = 8'd5;
	localparam logic [TickW-1:0]  READ_TICK_RST   = 8'd75;

	localparam logic [DelayW-1:0] ELAPSED_MAX = {DelayW{1'b1}};
	localparam logic [WordW-1:0]  POLL_MAX    = {WordW{1'b1}};

endpackage

// ----- rtl/core/spi_range_sensor_poller_top.sv -----
// ----------------------------------------------------------------------------
// SPI range sensor poller
// Tracks the link to an ultrasonic range board, issues alive, fire and read
// commands on millisecond ticks and checks each SPI reply.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  in        in_valid / in_stall    req_type, rx_flag, rx_word
//  out       out_valid / out_stall  cmd_valid, cmd_word, range_valid,
//                                   range_value, link_up
//  cfg       cfg_we                 cfg_index, cfg_data
//
//  Every input beat yields exactly one output beat: it passes through the
//  input register and then the result register.
//  One beat is taken per cycle while in_stall is low; the single
//  compare-and-update pass between the input and result registers allows it.
//  in_stall rises only when both the input and the result register are full
//  and out_stall is high. arst_n resets all control state and the registers.
// ----------------------------------------------------------------------------
module spi_range_sensor_poller_top
	import spp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic                rx_flag,
	input  logic [WordW-1:0]    rx_word,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic                cmd_valid,
	output logic [WordW-1:0]    cmd_word,
	output logic                range_valid,
	output logic [ByteW-1:0]    range_value,
	output logic                link_up,
	// configuration
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	// Configuration registers
	logic [DelayW-1:0] start_delay_q;
	logic [TickW-1:0]  fire_tick_q;
	logic [TickW-1:0]  read_tick_q;

	// Poller state
	logic [DelayW-1:0] elapsed_q;
	logic              link_q;
	logic              fire_pend_q;
	logic [WordW-1:0]  poll_q;
	logic [WordW-1:0]  last_cmd_q;
	logic [WordW-1:0]  last_rx_q;
	logic [ByteW-1:0]  sample_q;
	logic              fresh_q;
	logic [ByteW-1:0]  range_q;

	// Input register
	logic              valid_s1;
	logic              req_s1;
	logic              flag_s1;
	logic [WordW-1:0]  word_s1;

	// Result register
	logic              valid_s2;
	logic              cmd_valid_s2;
	logic [WordW-1:0]  cmd_word_s2;
	logic              range_valid_s2;
	logic [ByteW-1:0]  range_s2;
	logic              link_s2;

	// Next-state values from the single update pass
	logic [DelayW-1:0] elapsed_d;
	logic              link_d;
	logic              fire_pend_d;
	logic [WordW-1:0]  poll_d;
	logic [WordW-1:0]  last_cmd_d;
	logic [WordW-1:0]  last_rx_d;
	logic [ByteW-1:0]  sample_d;
	logic              fresh_d;
	logic [ByteW-1:0]  range_d;
	logic              cmd_valid_d;
	logic [WordW-1:0]  cmd_word_d;
	logic              range_valid_d;

	logic              adv_s1;   // s1 beat moves into the result register
	logic              take_in;  // input beat accepted

	// Advance whenever the result register is empty or being drained
	assign adv_s1   = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & valid_s2 & out_stall;
	assign take_in  = in_valid & ~in_stall;

	// Configuration writes; an unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delay_q <= START_DELAY_RST;
			fire_tick_q   <= FIRE_TICK_RST;
			read_tick_q   <= READ_TICK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_DELAY: start_delay_q <= cfg_data;
				CFG_FIRE_TICK:   fire_tick_q   <= cfg_data[TickW-1:0];
				CFG_READ_TICK:   read_tick_q   <= cfg_data[TickW-1:0];
				default: ;
			endcase
		end
	end

	// Input register: load on accept, empty when drained with nothing behind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			req_s1   <= REQ_TICK;
			flag_s1  <= 1'b0;
			word_s1  <= '0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
				req_s1   <= req_type;
				flag_s1  <= rx_flag;
				word_s1  <= rx_word;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// One pass over the beat in s1 against the current state
	always_comb begin
		elapsed_d     = elapsed_q;
		link_d        = link_q;
		fire_pend_d   = fire_pend_q;
		poll_d        = poll_q;
		last_cmd_d    = last_cmd_q;
		last_rx_d     = last_rx_q;
		sample_d      = sample_q;
		fresh_d       = fresh_q;
		range_d       = range_q;
		cmd_valid_d   = 1'b0;
		cmd_word_d    = CMD_NONE;
		range_valid_d = 1'b0;

		if (req_s1 == REQ_XFER) begin
			// Keep the previous word unless the status says it is valid
			if (flag_s1) begin
				last_rx_d = word_s1;
			end
			// Check the reply against the last command sent
			case (last_cmd_q)
				CMD_FIRE: begin
					if (last_rx_d == ACK_A || last_rx_d == ACK_B) begin
						fire_pend_d = 1'b0;
					end else begin
						link_d = 1'b0;
					end
				end
				CMD_READ: begin
					if ((last_rx_d & DATA_MASK) == DATA_TAG) begin
						sample_d    = last_rx_d[ByteW-1:0];
						fresh_d     = 1'b1;
						fire_pend_d = 1'b1;
						poll_d      = '0;
					end else begin
						link_d = 1'b0;
					end
				end
				CMD_ALIVE: begin
					if (last_rx_d == ACK_B) begin
						link_d      = 1'b1;
						fire_pend_d = 1'b1;
						poll_d      = '0;
					end
				end
				default: ;
			endcase
		end else begin
			// Publish an unconsumed sample first
			if (fresh_q) begin
				range_d       = sample_q;
				fresh_d       = 1'b0;
				range_valid_d = 1'b1;
			end
			if (elapsed_q > start_delay_q) begin
				if (link_q) begin
					if (poll_q != POLL_MAX) begin
						poll_d = poll_q + 1'b1;
					end
					if (fire_pend_q) begin
						if (poll_d == {{(WordW-TickW){1'b0}}, fire_tick_q}) begin
							cmd_word_d = CMD_FIRE;
						end
					end else if (poll_d == {{(WordW-TickW){1'b0}}, read_tick_q}) begin
						cmd_word_d = CMD_READ;
					end
				end else begin
					// Link down: probe every tick
					cmd_word_d = CMD_ALIVE;
				end
				if (cmd_word_d != CMD_NONE) begin
					cmd_valid_d = 1'b1;
					last_cmd_d  = cmd_word_d;
				end
			end
			if (elapsed_q != ELAPSED_MAX) begin
				elapsed_d = elapsed_q + 1'b1;
			end
		end
	end

	// State and result register update together as the beat leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q      <= 12'd1;
			link_q         <= 1'b0;
			fire_pend_q    <= 1'b1;
			poll_q         <= '0;
			last_cmd_q     <= CMD_NONE;
			last_rx_q      <= '0;
			sample_q       <= '0;
			fresh_q        <= 1'b0;
			range_q        <= '0;
			valid_s2       <= 1'b0;
			cmd_valid_s2   <= 1'b0;
			cmd_word_s2    <= CMD_NONE;
			range_valid_s2 <= 1'b0;
			range_s2       <= '0;
			link_s2        <= 1'b0;
		end else begin
			if (adv_s1) begin
				elapsed_q      <= elapsed_d;
				link_q         <= link_d;
				fire_pend_q    <= fire_pend_d;
				poll_q         <= poll_d;
				last_cmd_q     <= last_cmd_d;
				last_rx_q      <= last_rx_d;
				sample_q       <= sample_d;
				fresh_q        <= fresh_d;
				range_q        <= range_d;
				valid_s2       <= 1'b1;
				cmd_valid_s2   <= cmd_valid_d;
				cmd_word_s2    <= cmd_word_d;
				range_valid_s2 <= range_valid_d;
				range_s2       <= range_d;
				link_s2        <= link_d;
			end else if (!out_stall) begin
				// Drop the delivered beat
				valid_s2 <= 1'b0;
			end
		end
	end

	assign out_valid   = valid_s2;
	assign cmd_valid   = cmd_valid_s2;
	assign cmd_word    = cmd_word_s2;
	assign range_valid = range_valid_s2;
	assign range_value = range_s2;
	assign link_up     = link_s2;

endmodule

// ----- rtl/core/spp_checker.sv -----
// ----------------------------------------------------------------------------
// SPI range poller port checker
// Watches the result channel of the poller for command and link consistency.
// ----------------------------------------------------------------------------
module spp_checker
	import spp_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_stall,
	input logic             cmd_valid,
	input logic [WordW-1:0] cmd_word,
	input logic             link_up
);

	// A sent command is one of the three known codes
	a_cmd_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cmd_valid |->
			(cmd_word == CMD_FIRE || cmd_word == CMD_READ || cmd_word == CMD_ALIVE))
		else $error("unknown command word sent");

	// No command means an empty command word
	a_cmd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cmd_valid |-> cmd_word == CMD_NONE)
		else $error("command word set without cmd_valid");

	// Fire and read go out only over a live link
	a_poll_link: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cmd_valid && (cmd_word == CMD_FIRE || cmd_word == CMD_READ)
			|-> link_up)
		else $error("poll command while link is down");

	// Alive probes go out only while the link is down
	a_probe_link: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cmd_valid && cmd_word == CMD_ALIVE |-> !link_up)
		else $error("alive probe while link is up");

	// A stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cmd_word) && $stable(link_up))
		else $error("stalled result beat changed");

endmodule

bind spi_range_sensor_poller_top spp_checker u_spp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.cmd_valid (cmd_valid),
	.cmd_word  (cmd_word),
	.link_up   (link_up)
);

// ----- bench/tb_spi_range_sensor_poller_top.sv -----
// ----------------------------------------------------------------------------
// SPI range poller testbench
// Drives ticks and finished SPI transfers into the poller and checks every
// result beat against a cycle-free model of its link, poll and sample logic.
// ----------------------------------------------------------------------------
module tb_spi_range_sensor_poller_top;
	import spp_pkg::*;

	// Slack after a drain for the input and result registers to empty
	localparam int SETTLE = 4;
	localparam int PHASE_BEATS = 100;
	localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic             cmd_valid;
		logic [WordW-1:0] cmd_word;
		logic             range_valid;
		logic [ByteW-1:0] range_value;
		logic             link_up;
	} poll_res_t;

	typedef enum bit {ROW_CFG, ROW_BEAT} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		logic [CfgIdxW-1:0]  idx;
		logic [CfgDataW-1:0] data;
		logic                req;
		logic                flag;
		logic [WordW-1:0]    word;
		bit                  pinned;
		poll_res_t           res;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                req_type = REQ_TICK;
	logic                rx_flag = 1'b0;
	logic [WordW-1:0]    rx_word = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                cmd_valid;
	logic [WordW-1:0]    cmd_word;
	logic                range_valid;
	logic [ByteW-1:0]    range_value;
	logic                link_up;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	// Poller model: configuration
	logic [DelayW-1:0] c_start_delay = START_DELAY_RST;
	logic [TickW-1:0]  c_fire_tick = FIRE_TICK_RST;
	logic [TickW-1:0]  c_read_tick = READ_TICK_RST;

	// Poller model: state, at its reset values
	logic [DelayW-1:0] p_elapsed = 12'd1;
	logic              p_link = 1'b0;
	logic              p_fire_pend = 1'b1;
	logic [WordW-1:0]  p_poll = '0;
	logic [WordW-1:0]  p_last_cmd = CMD_NONE;
	logic [WordW-1:0]  p_last_rx = '0;
	logic [ByteW-1:0]  p_sample = '0;
	logic              p_fresh = 1'b0;
	logic [ByteW-1:0]  p_range = '0;

	poll_res_t poller_out_q[$];
	dir_row_t  dir_tab[$];
	int        mismatch_cnt = 0;
	int        gap_pct = 0;
	int        stall_pct = 0;
	bit        reply_owed = 1'b0;

	spi_range_sensor_poller_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.rx_flag     (rx_flag),
		.rx_word     (rx_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cmd_valid   (cmd_valid),
		.cmd_word    (cmd_word),
		.range_valid (range_valid),
		.range_value (range_value),
		.link_up     (link_up),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Advance the poller model by one accepted input beat
	function automatic poll_res_t poller_step(logic req, logic flag, logic [WordW-1:0] word);
		poll_res_t r;
		r = '0;
		if (req == REQ_XFER) begin
			// Check the reply against the last command; the command is kept,
			// so a further transfer repeats the same check
			if (flag)
				p_last_rx = word;
			case (p_last_cmd)
				CMD_FIRE: begin
					if (p_last_rx == ACK_A || p_last_rx == ACK_B)
						p_fire_pend = 1'b0;
					else
						p_link = 1'b0;
				end
				CMD_READ: begin
					if ((p_last_rx & DATA_MASK) == DATA_TAG) begin
						p_sample = p_last_rx[ByteW-1:0];
						p_fresh = 1'b1;
						p_fire_pend = 1'b1;
						p_poll = '0;
					end else begin
						p_link = 1'b0;
					end
				end
				CMD_ALIVE: begin
					if (p_last_rx == ACK_B) begin
						p_link = 1'b1;
						p_fire_pend = 1'b1;
						p_poll = '0;
					end
				end
				default: ;
			endcase
		end else begin
			if (p_fresh) begin
				p_range = p_sample;
				p_fresh = 1'b0;
				r.range_valid = 1'b1;
			end
			if (p_elapsed > c_start_delay) begin
				if (p_link) begin
					if (p_poll != POLL_MAX)
						p_poll = p_poll + 1'b1;
					if (p_fire_pend) begin
						if (p_poll == WordW'(c_fire_tick))
							r.cmd_word = CMD_FIRE;
					end else if (p_poll == WordW'(c_read_tick)) begin
						r.cmd_word = CMD_READ;
					end
				end else begin
					r.cmd_word = CMD_ALIVE;
				end
				if (r.cmd_word != CMD_NONE) begin
					r.cmd_valid = 1'b1;
					p_last_cmd = r.cmd_word;
				end
			end
			if (p_elapsed != ELAPSED_MAX)
				p_elapsed = p_elapsed + 1'b1;
		end
		r.range_value = p_range;
		r.link_up = p_link;
		return r;
	endfunction

	function automatic void add_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		dir_row_t row;
		row.kind = ROW_CFG;
		row.idx = idx;
		row.data = data;
		row.req = 1'b0;
		row.flag = 1'b0;
		row.word = '0;
		row.pinned = 1'b0;
		row.res = '0;
		dir_tab.push_back(row);
	endfunction

	function automatic void add_beat(logic req, logic flag, logic [WordW-1:0] word);
		dir_row_t row;
		row.kind = ROW_BEAT;
		row.idx = '0;
		row.data = '0;
		row.req = req;
		row.flag = flag;
		row.word = word;
		row.pinned = 1'b0;
		row.res = '0;
		dir_tab.push_back(row);
	endfunction

	// A beat whose result is typed in by hand
	function automatic void add_known(logic req, logic flag, logic [WordW-1:0] word,
			logic cv, logic [WordW-1:0] cw, logic rv, logic [ByteW-1:0] rval, logic lk);
		add_beat(req, flag, word);
		dir_tab[dir_tab.size()-1].pinned = 1'b1;
		dir_tab[dir_tab.size()-1].res = {cv, cw, rv, rval, lk};
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_cnt++;
		$display("MISMATCH %s", msg);
	endtask

	task automatic check_field(string name, logic [WordW-1:0] got, logic [WordW-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h at %0t", name, got, want, $time));
	endtask

	// Send one input beat after a random gap; model it once it is taken
	task automatic send_beat(input logic req, input logic flag, input logic [WordW-1:0] word,
			input bit pinned, input poll_res_t pinned_res, output poll_res_t res);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		rx_flag <= flag;
		rx_word <= word;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		res = poller_step(req, flag, word);
		poller_out_q.push_back(pinned ? pinned_res : res);
	endtask

	// Hold the sender until every expected result has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (poller_out_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write one register while idle; tick registers get random upper data bits
	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		logic [CfgDataW-1:0] d;
		drain();
		d = CfgDataW'($urandom_range(4095));
		if (idx == CFG_FIRE_TICK || idx == CFG_READ_TICK)
			d[TickW-1:0] = data[TickW-1:0];
		else
			d = data;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_START_DELAY: c_start_delay = d;
			CFG_FIRE_TICK:   c_fire_tick = d[TickW-1:0];
			CFG_READ_TICK:   c_read_tick = d[TickW-1:0];
			default: ;
		endcase
	endtask

	task automatic tick_run(int n);
		poll_res_t r;
		repeat (n)
			send_beat(REQ_TICK, 1'($urandom_range(1)), WordW'($urandom_range(16'hFFFF)),
				1'b0, '0, r);
	endtask

	// Bring the link up with a fresh poll count: drop it with a bad reply if
	// needed, let an alive probe out, then answer it
	task automatic relink();
		poll_res_t r;
		while (!(p_link && p_poll == '0 && p_fire_pend)) begin
			if (p_last_cmd == CMD_ALIVE)
				send_beat(REQ_XFER, 1'b1, ACK_B, 1'b0, '0, r);
			else if (p_link && p_last_cmd != CMD_NONE)
				send_beat(REQ_XFER, 1'b1, 16'h0000, 1'b0, '0, r);
			else
				send_beat(REQ_TICK, 1'b0, '0, 1'b0, '0, r);
		end
	endtask

	// Mostly well-formed traffic: a command tick is usually answered by the
	// matching reply, with bad replies, stale-word transfers and stray
	// transfers mixed in
	task automatic send_random_beat();
		poll_res_t r;
		logic [WordW-1:0] w;
		int roll;
		roll = $urandom_range(99);
		w = WordW'($urandom_range(16'hFFFF));
		if (reply_owed && roll < 85) begin
			if ($urandom_range(99) < 85) begin
				case (p_last_cmd)
					CMD_FIRE:  w = $urandom_range(1) ? ACK_A : ACK_B;
					CMD_READ:  w = DATA_TAG | WordW'($urandom_range(255));
					CMD_ALIVE: w = ACK_B;
					default: ;
				endcase
			end
			send_beat(REQ_XFER, $urandom_range(99) >= 8, w, 1'b0, '0, r);
			reply_owed = 1'b0;
		end else if (roll >= 88) begin
			send_beat(REQ_XFER, 1'($urandom_range(1)), w, 1'b0, '0, r);
		end else begin
			send_beat(REQ_TICK, 1'($urandom_range(1)), w, 1'b0, '0, r);
			if (r.cmd_valid)
				reply_owed = 1'b1;
		end
	endtask

	// Receiver stalls at the rate of the current phase
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin : result_check
		poll_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (poller_out_q.size() == 0) begin
				report_mismatch($sformatf("result beat with none expected at %0t", $time));
			end else begin
				want = poller_out_q.pop_front();
				check_field("cmd_valid", WordW'(cmd_valid), WordW'(want.cmd_valid));
				check_field("cmd_word", cmd_word, want.cmd_word);
				check_field("range_valid", WordW'(range_valid), WordW'(want.range_valid));
				check_field("range_value", WordW'(range_value), WordW'(want.range_value));
				check_field("link_up", WordW'(link_up), WordW'(want.link_up));
			end
		end
	end

	initial begin : stimulus
		poll_res_t r;
		int f;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reply before any command, start-up delay gate, every
		// reply check good and bad, stale-word transfers, range publish of
		// both byte extremes, and a write to the unused register index
		add_known(REQ_XFER, 1'b1, ACK_B,   1'b0, CMD_NONE,  1'b0, 8'h00, 1'b0);
		add_known(REQ_TICK, 1'b0, '0,      1'b0, CMD_NONE,  1'b0, 8'h00, 1'b0);
		add_cfg(CFG_START_DELAY, 12'd0);
		add_known(REQ_TICK, 1'b1, 16'hFFFF, 1'b1, CMD_ALIVE, 1'b0, 8'h00, 1'b0);
		add_known(REQ_XFER, 1'b1, 16'h1234, 1'b0, CMD_NONE,  1'b0, 8'h00, 1'b0);
		add_known(REQ_XFER, 1'b0, 16'hFFFF, 1'b0, CMD_NONE,  1'b0, 8'h00, 1'b0);
		add_known(REQ_XFER, 1'b1, ACK_B,   1'b0, CMD_NONE,  1'b0, 8'h00, 1'b1);
		add_cfg(CFG_FIRE_TICK, 12'd1);
		add_cfg(CFG_READ_TICK, 12'd2);
		add_known(REQ_TICK, 1'b0, '0,      1'b1, CMD_FIRE,  1'b0, 8'h00, 1'b1);
		add_known(REQ_XFER, 1'b1, ACK_A,   1'b0, CMD_NONE,  1'b0, 8'h00, 1'b1);
		add_known(REQ_TICK, 1'b0, '0,      1'b1, CMD_READ,  1'b0, 8'h00, 1'b1);
		add_known(REQ_XFER, 1'b1, 16'hDDFF, 1'b0, CMD_NONE, 1'b0, 8'h00, 1'b1);
		add_known(REQ_XFER, 1'b0, 16'h0000, 1'b0, CMD_NONE, 1'b0, 8'h00, 1'b1);
		add_known(REQ_TICK, 1'b0, '0,      1'b1, CMD_FIRE,  1'b1, 8'hFF, 1'b1);
		add_known(REQ_XFER, 1'b1, ACK_B,   1'b0, CMD_NONE,  1'b0, 8'hFF, 1'b1);
		add_known(REQ_TICK, 1'b0, '0,      1'b1, CMD_READ,  1'b0, 8'hFF, 1'b1);
		add_known(REQ_XFER, 1'b1, DATA_TAG, 1'b0, CMD_NONE, 1'b0, 8'hFF, 1'b1);
		add_known(REQ_TICK, 1'b0, '0,      1'b1, CMD_FIRE,  1'b1, 8'h00, 1'b1);
		add_known(REQ_XFER, 1'b1, 16'h0000, 1'b0, CMD_NONE, 1'b0, 8'h00, 1'b0);
		add_known(REQ_TICK, 1'b0, '0,      1'b1, CMD_ALIVE, 1'b0, 8'h00, 1'b0);
		add_beat(REQ_XFER, 1'b1, ACK_B);
		add_beat(REQ_TICK, 1'b0, '0);
		add_beat(REQ_XFER, 1'b1, ACK_A);
		add_beat(REQ_TICK, 1'b0, '0);
		add_known(REQ_XFER, 1'b1, 16'h1200, 1'b0, CMD_NONE, 1'b0, 8'h00, 1'b0);
		add_cfg(CFG_SPARE, 12'hFFF);
		add_known(REQ_TICK, 1'b0, '0,      1'b1, CMD_ALIVE, 1'b0, 8'h00, 1'b0);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG)
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			else
				send_beat(dir_tab[i].req, dir_tab[i].flag, dir_tab[i].word,
					dir_tab[i].pinned, dir_tab[i].res, r);
		end

		// Random phases, each with its own settings and idling pattern
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					// Start delay just ahead of the tick count: the gate opens mid-phase
					gap_pct = 0;
					stall_pct = 0;
					write_reg(CFG_START_DELAY, p_elapsed + 12'd25);
					write_reg(CFG_FIRE_TICK, 12'd2);
					write_reg(CFG_READ_TICK, 12'd5);
				end
				1: begin
					gap_pct = 85;
					stall_pct = 0;
					f = $urandom_range(1, 6);
					write_reg(CFG_START_DELAY, CfgDataW'($urandom_range(15)));
					write_reg(CFG_FIRE_TICK, CfgDataW'(f));
					write_reg(CFG_READ_TICK, CfgDataW'(f + $urandom_range(1, 8)));
				end
				2: begin
					// Ticks may be zero or out of order here
					gap_pct = 0;
					stall_pct = 85;
					write_reg(CFG_START_DELAY, CfgDataW'($urandom_range(15)));
					write_reg(CFG_FIRE_TICK, CfgDataW'($urandom_range(4)));
					write_reg(CFG_READ_TICK, CfgDataW'($urandom_range(10)));
				end
				default: begin
					gap_pct = 15;
					stall_pct = 15;
					f = $urandom_range(1, 5);
					write_reg(CFG_START_DELAY, CfgDataW'($urandom_range(15)));
					write_reg(CFG_FIRE_TICK, CfgDataW'(f));
					write_reg(CFG_READ_TICK, CfgDataW'(f + $urandom_range(1, 5)));
				end
			endcase
			for (int n = 0; n < PHASE_BEATS; n++) begin
				// Hold the sender once per phase until the pipe is empty
				if (n == PHASE_BEATS / 2)
					drain();
				send_random_beat();
			end
		end

		// Largest start delay: the tick count can never pass it, so no
		// command may go out
		gap_pct = 0;
		stall_pct = 0;
		write_reg(CFG_START_DELAY, ELAPSED_MAX);
		tick_run(20);
		write_reg(CFG_START_DELAY, 12'd0);

		// Fire and read at the top of the poll tick range
		write_reg(CFG_FIRE_TICK, 12'd254);
		write_reg(CFG_READ_TICK, 12'd255);
		relink();
		tick_run(254);
		send_beat(REQ_XFER, 1'b1, ACK_A, 1'b0, '0, r);
		tick_run(6);

		stall_pct = 15;
		drain();
		if (mismatch_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog
	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
